// ===== sv/bounded_set_store_macros.svh =====
// Assertion macros shared by the bounded set store modules.
// No dependencies; include this file with a bare file name.
`ifndef BOUNDED_SET_STORE_MACROS_SVH
`define BOUNDED_SET_STORE_MACROS_SVH
`ifndef SYNTHESIS
`define BSS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BSS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BSS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BSS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/bss_pkg.sv =====
// Shared types and constants for the bounded set store.
// No dependencies.
package bss_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int ELEM_W    = 32;
    localparam int CMD_W     = 3;
    localparam int CAP_W     = 7;
    localparam int COUNT_W   = 7;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MEMBER     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ITER_RESET = 3'd3;
    localparam logic [CMD_W-1:0] CMD_ITER_NEXT  = 3'd4;

    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_SHIFT,
        ST_ITER,
        ST_DONE
    } ctl_state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic shift_start;
        logic shift;
        logic append;
        logic rm_commit;
        logic iter_reset;
        logic iter_rd;
        logic iter_take;
        logic ok_we;
        logic ok_val;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] op;
        logic             full;
        logic             iter_avail;
        logic             scan_done;
        logic             hit;
        logic             shift_done;
    } dp_status_t;

endpackage

// ===== sv/bss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/bss_ctl.sv =====
// Controller state machine of the bounded set store.
// Depends on bss_pkg and bounded_set_store_macros.svh.
`include "bounded_set_store_macros.svh"
module bss_ctl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  bss_pkg::dp_status_t  status,
    output bss_pkg::dp_cmd_t     cmd
);
    import bss_pkg::*;

    ctl_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (status.op)
                    CMD_INSERT: begin
                        if (status.full) begin
                            cmd.ok_we  = 1'b1;
                            cmd.ok_val = 1'b0;
                            state_next = ST_DONE;
                        end else begin
                            state_next = ST_SCAN;
                        end
                    end
                    CMD_REMOVE, CMD_MEMBER: begin
                        state_next = ST_SCAN;
                    end
                    CMD_ITER_RESET: begin
                        cmd.iter_reset = 1'b1;
                        cmd.ok_we      = 1'b1;
                        cmd.ok_val     = 1'b1;
                        state_next     = ST_DONE;
                    end
                    CMD_ITER_NEXT: begin
                        if (status.iter_avail) begin
                            cmd.iter_rd = 1'b1;
                            state_next  = ST_ITER;
                        end else begin
                            cmd.ok_we  = 1'b1;
                            cmd.ok_val = 1'b0;
                            state_next = ST_DONE;
                        end
                    end
                    default: begin
                        cmd.ok_we  = 1'b1;
                        cmd.ok_val = 1'b0;
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (status.scan_done) begin
                    if (status.op == CMD_REMOVE && status.hit) begin
                        cmd.shift_start = 1'b1;
                        state_next      = ST_SHIFT;
                    end else begin
                        cmd.ok_we  = 1'b1;
                        cmd.ok_val = status.hit || (status.op == CMD_INSERT);
                        cmd.append = (status.op == CMD_INSERT) && !status.hit;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SHIFT: begin
                cmd.shift = 1'b1;
                if (status.shift_done) begin
                    cmd.rm_commit = 1'b1;
                    cmd.ok_we     = 1'b1;
                    cmd.ok_val    = 1'b1;
                    state_next    = ST_DONE;
                end
            end
            ST_ITER: begin
                cmd.iter_take = 1'b1;
                cmd.ok_we     = 1'b1;
                cmd.ok_val    = 1'b1;
                state_next    = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

    `BSS_ASSERT_IMP(a_load_free, aclk, aresetn, cmd.out_load, !m_valid_reg || m_ready)
    `BSS_ASSERT_NXT(a_accept_decode, aclk, aresetn, s_valid && s_ready, state_reg == ST_DECODE)
    `BSS_ASSERT_NXT(a_result_held, aclk, aresetn, m_valid_reg && !m_ready, m_valid_reg)

endmodule

// ===== sv/bss_datapath.sv =====
// Datapath of the bounded set store: entry memory, count, iterator, scan and shift.
// Depends on bss_pkg, bss_ram and bounded_set_store_macros.svh.
`include "bounded_set_store_macros.svh"
module bss_datapath #(
    parameter int DEPTH = bss_pkg::DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  bss_pkg::dp_cmd_t                  cmd,
    output bss_pkg::dp_status_t               status,
    input  logic [bss_pkg::CAP_W-1:0]         cap,
    input  logic [bss_pkg::CMD_W-1:0]         s_cmd,
    input  logic signed [bss_pkg::ELEM_W-1:0] s_element,
    output logic                              m_ok,
    output logic signed [bss_pkg::ELEM_W-1:0] m_element_out,
    output logic [bss_pkg::COUNT_W-1:0]       m_count,
    output logic                              m_is_empty
);
    import bss_pkg::*;

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  iter_reg, iter_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  pend_idx_reg, pend_idx_next;
    logic [CMD_W-1:0]  op_reg;
    logic [ELEM_W-1:0] elem_reg;
    logic              ok_reg;
    logic [ELEM_W-1:0] eout_reg;
    logic              m_ok_reg;
    logic [ELEM_W-1:0] m_eout_reg;
    logic [COUNT_W-1:0] m_count_reg;
    logic              m_empty_reg;

    logic              eq, more, issue;
    logic [CNT_W-1:0]  back_idx;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [ELEM_W-1:0] ram_wdata, ram_rdata;

    bss_ram #(
        .WIDTH(ELEM_W),
        .DEPTH(DEPTH)
    ) u_entries (
        .clk  (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign eq       = pend_valid_reg && (ram_rdata == elem_reg);
    assign more     = idx_reg < count_reg;
    assign issue    = (cmd.scan && !eq && more) || (cmd.shift && more);
    assign back_idx = pend_idx_reg - CNT_W'(1);

    assign status.op         = op_reg;
    assign status.full       = (CMP_W'(count_reg) >= CMP_W'(cap)) ||
                               (count_reg == CNT_W'(DEPTH));
    assign status.iter_avail = iter_reg < count_reg;
    assign status.scan_done  = eq || (!pend_valid_reg && !more);
    assign status.hit        = eq;
    assign status.shift_done = !pend_valid_reg && !more;

    assign ram_we    = cmd.append || (cmd.shift && pend_valid_reg);
    assign ram_waddr = cmd.append ? count_reg[ADDR_W-1:0] : back_idx[ADDR_W-1:0];
    assign ram_wdata = cmd.append ? elem_reg : ram_rdata;
    assign ram_raddr = cmd.iter_rd ? iter_reg[ADDR_W-1:0] : idx_reg[ADDR_W-1:0];

    always_comb begin
        idx_next        = idx_reg;
        pend_idx_next   = pend_idx_reg;
        pend_valid_next = issue;
        if (cmd.load) begin
            idx_next = '0;
        end
        if (issue) begin
            idx_next      = idx_reg + CNT_W'(1);
            pend_idx_next = idx_reg;
        end
        if (cmd.shift_start) begin
            idx_next = pend_idx_reg + CNT_W'(1);
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.append) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.rm_commit) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb begin
        iter_next = iter_reg;
        if (cmd.iter_reset) begin
            iter_next = '0;
        end else if (cmd.iter_take) begin
            iter_next = iter_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            iter_reg       <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            count_reg      <= count_next;
            iter_reg       <= iter_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        pend_idx_reg <= pend_idx_next;
        if (cmd.load) begin
            op_reg   <= s_cmd;
            elem_reg <= s_element;
            eout_reg <= '0;
        end else if (cmd.iter_take) begin
            eout_reg <= ram_rdata;
        end
        if (cmd.ok_we) begin
            ok_reg <= cmd.ok_val;
        end
        if (cmd.out_load) begin
            m_ok_reg    <= ok_reg;
            m_eout_reg  <= eout_reg;
            m_count_reg <= COUNT_W'(count_reg);
            m_empty_reg <= (count_reg == '0);
        end
    end

    assign m_ok          = m_ok_reg;
    assign m_element_out = $signed(m_eout_reg);
    assign m_count       = m_count_reg;
    assign m_is_empty    = m_empty_reg;

    `BSS_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(DEPTH))
    `BSS_ASSERT_IMP(a_append_room, aclk, aresetn, cmd.append, count_reg < CNT_W'(DEPTH))
    `BSS_ASSERT_IMP(a_remove_nonempty, aclk, aresetn, cmd.rm_commit, count_reg != '0)
    `BSS_ASSERT_IMP(a_shift_addr, aclk, aresetn, cmd.shift && pend_valid_reg,
        pend_idx_reg != '0)

endmodule

// ===== sv/bounded_set_store.sv =====
// Top level of the bounded set store: APB capacity register, controller and datapath.
// Depends on bss_pkg, bss_ctl and bss_datapath.
//
//   Channel  Direction  Handshake          Payload
//   s_       in         s_valid/s_ready    s_cmd, s_element
//   m_       out        m_valid/m_ready    m_ok, m_element_out, m_count, m_is_empty
//   apb      in         psel/penable       paddr, pwrite, pwdata, prdata
//
// One request is handled at a time. Insert, remove and member scan the stored entries
// through the registered memory read; a remove that hits also shifts the later entries
// down. A full insert, an unknown command and iterator requests do not scan the entries.
// A finished result waits in the output register while the next request is accepted; a
// new result stalls only while that register still holds one. Reset needs no clearing pass.
module bounded_set_store #(
    parameter int DEPTH = bss_pkg::DEPTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [bss_pkg::CMD_W-1:0]          s_cmd,
    input  logic signed [bss_pkg::ELEM_W-1:0]  s_element,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_ok,
    output logic signed [bss_pkg::ELEM_W-1:0]  m_element_out,
    output logic [bss_pkg::COUNT_W-1:0]        m_count,
    output logic                               m_is_empty,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bss_pkg::PADDR_W-1:0]        paddr,
    input  logic [bss_pkg::PDATA_W-1:0]        pwdata,
    output logic [bss_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready
);
    import bss_pkg::*;

    logic [CAP_W-1:0] cap_reg;
    logic             reg_sel;
    dp_cmd_t          cmd;
    dp_status_t       status;

    assign pready  = 1'b1;
    assign reg_sel = paddr[PADDR_W-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel == REG_CAPACITY) begin
            cap_reg <= pwdata[CAP_W-1:0];
        end
    end

    assign prdata = (reg_sel == REG_CAPACITY) ? PDATA_W'(cap_reg) : '0;

    bss_ctl u_ctl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .status (status),
        .cmd    (cmd)
    );

    bss_datapath #(
        .DEPTH(DEPTH)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .cap          (cap_reg),
        .s_cmd        (s_cmd),
        .s_element    (s_element),
        .m_ok         (m_ok),
        .m_element_out(m_element_out),
        .m_count      (m_count),
        .m_is_empty   (m_is_empty)
    );

endmodule
